// ----- src/yt_pkg.sv -----
// shared types and constants for the young tableau priority queue
// no dependencies; used by yt_ctrl, yt_datapath and the top level
package yt_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  // empty cell marker, the largest signed key
  localparam logic signed [DATA_W-1:0] KEY_EMPTY = 32'sh7FFF_FFFF;

  localparam logic [CFG_W-1:0] ROWS_RESET = 4'd8;
  localparam logic [CFG_W-1:0] COLS_RESET = 4'd8;

  // request codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic clear_wr;  // write empty marker at the clear counter
    logic start;     // take a new request
    logic fetch;     // read the starting cell
    logic grab;      // capture the starting cell into the result
    logic read;      // read both neighbours of the current cell
    logic eval;      // compare, write current cell, move or finish
    logic load_out;  // move the result into the output register
  } yt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic stop;
  } yt_stat_t;

endpackage

// ----- src/yt_ctrl.sv -----
// controller for the young tableau queue: clearing pass, sift sequencing
// and output register handshake; depends on yt_pkg
module yt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output yt_pkg::yt_cmd_t  cmd_o,
  input  yt_pkg::yt_stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_GRAB,
    ST_READ,
    ST_EVAL,
    ST_WAIT_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_GRAB;
      end
      ST_GRAB: begin
        // starting cell arrives while the neighbours are requested
        cmd_o.grab = 1'b1;
        cmd_o.read = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!stat_i.stop) begin
          state_d = ST_READ;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_WAIT_OUT;
        end
      end
      ST_WAIT_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/yt_datapath.sv -----
// datapath for the young tableau queue: cell memory, position registers,
// neighbour compare and output register; depends on yt_pkg
module yt_datapath #(
  parameter int MaxRows = yt_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = yt_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  yt_pkg::yt_cmd_t                 cmd_i,
  output yt_pkg::yt_stat_t                stat_o,
  input  logic [yt_pkg::CFG_W-1:0]        rows_cfg_i,
  input  logic [yt_pkg::CFG_W-1:0]        cols_cfg_i,
  input  logic                            req_type_i,
  input  logic signed [yt_pkg::DATA_W-1:0] key_value_i,
  output logic signed [yt_pkg::DATA_W-1:0] min_value_o,
  output logic                            table_was_empty_o,
  output logic                            dropped_valid_o,
  output logic signed [yt_pkg::DATA_W-1:0] dropped_value_o
);

  localparam int Depth = MaxRows * MaxCols;
  localparam int RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef logic signed [yt_pkg::DATA_W-1:0] key_t;

  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                 input logic [ColW-1:0] c);
    return AddrW'(int'(r) * MaxCols + int'(c));
  endfunction

  // cell store, two registered read ports and one write port
  key_t             cells_q [Depth];
  key_t             rd_a_q, rd_b_q;
  logic [AddrW-1:0] raddr_a, raddr_b, waddr;
  key_t             wdata;
  logic             wen;

  logic [AddrW-1:0] clr_q;
  logic             op_q;
  key_t             key_q;
  logic [RowW-1:0]  r_q, last_row, row_a;
  logic [ColW-1:0]  c_q, last_col, col_b;

  key_t res_min_q, res_dval_q;
  logic res_empty_q, res_dv_q;

  logic has_up, has_left, has_down, has_right, is_insert;
  logic go_up, go_down, ins_stop, ext_stop, stop;
  key_t ins_pick, down_val, right_val, ext_pick, pick;

  // clamp the size registers to the built grid
  always_comb begin
    if (rows_cfg_i == '0) begin
      last_row = '0;
    end else if (int'(rows_cfg_i) > MaxRows) begin
      last_row = RowW'(MaxRows - 1);
    end else begin
      last_row = RowW'(rows_cfg_i - 1'b1);
    end
    if (cols_cfg_i == '0) begin
      last_col = '0;
    end else if (int'(cols_cfg_i) > MaxCols) begin
      last_col = ColW'(MaxCols - 1);
    end else begin
      last_col = ColW'(cols_cfg_i - 1'b1);
    end
  end

  assign is_insert = (op_q == yt_pkg::OP_INSERT);
  assign has_up    = (r_q != '0);
  assign has_left  = (c_q != '0);
  assign has_down  = (r_q < last_row);
  assign has_right = (c_q < last_col);

  // neighbour positions, held on the current cell when missing
  always_comb begin
    if (is_insert) begin
      row_a = has_up ? r_q - 1'b1 : r_q;
      col_b = has_left ? c_q - 1'b1 : c_q;
    end else begin
      row_a = has_down ? r_q + 1'b1 : r_q;
      col_b = has_right ? c_q + 1'b1 : c_q;
    end
  end

  assign raddr_a = cmd_i.fetch ? cell_addr(r_q, c_q) : cell_addr(row_a, c_q);
  assign raddr_b = cell_addr(r_q, col_b);

  // insert: port a holds the upper cell, port b the left one
  always_comb begin
    if (has_up && has_left) begin
      go_up = (rd_a_q >= rd_b_q);
    end else begin
      go_up = has_up;
    end
    ins_pick = go_up ? rd_a_q : rd_b_q;
    ins_stop = (!has_up && !has_left) || (ins_pick <= key_q);
  end

  // extract: port a holds the lower cell, port b the right one
  always_comb begin
    down_val  = has_down ? rd_a_q : yt_pkg::KEY_EMPTY;
    right_val = has_right ? rd_b_q : yt_pkg::KEY_EMPTY;
    go_down   = (down_val <= right_val);
    ext_pick  = go_down ? down_val : right_val;
    ext_stop  = (down_val == yt_pkg::KEY_EMPTY) && (right_val == yt_pkg::KEY_EMPTY);
  end

  assign stop = is_insert ? ins_stop : ext_stop;
  assign pick = is_insert ? ins_pick : ext_pick;

  assign stat_o.stop       = stop;
  assign stat_o.clear_done = (clr_q == AddrW'(Depth - 1));

  always_comb begin
    wen   = 1'b0;
    waddr = cell_addr(r_q, c_q);
    wdata = pick;
    if (cmd_i.clear_wr) begin
      wen   = 1'b1;
      waddr = clr_q;
      wdata = yt_pkg::KEY_EMPTY;
    end else if (cmd_i.eval) begin
      wen = 1'b1;
      if (stop) begin
        wdata = is_insert ? key_q : yt_pkg::KEY_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      cells_q[waddr] <= wdata;
    end
    rd_a_q <= cells_q[raddr_a];
    rd_b_q <= cells_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr && !stat_o.clear_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= req_type_i;
      key_q <= key_value_i;
      if (req_type_i == yt_pkg::OP_INSERT) begin
        r_q <= last_row;
        c_q <= last_col;
      end else begin
        r_q <= '0;
        c_q <= '0;
      end
    end else if (cmd_i.eval && !stop) begin
      if (is_insert) begin
        if (go_up) begin
          r_q <= r_q - 1'b1;
        end else begin
          c_q <= c_q - 1'b1;
        end
      end else begin
        if (go_down) begin
          r_q <= r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end

    if (cmd_i.grab) begin
      if (is_insert) begin
        res_min_q   <= yt_pkg::KEY_EMPTY;
        res_empty_q <= 1'b0;
        res_dv_q    <= (rd_a_q != yt_pkg::KEY_EMPTY);
        res_dval_q  <= rd_a_q;
      end else begin
        res_min_q   <= rd_a_q;
        res_empty_q <= (rd_a_q == yt_pkg::KEY_EMPTY);
        res_dv_q    <= 1'b0;
        res_dval_q  <= yt_pkg::KEY_EMPTY;
      end
    end

    if (cmd_i.load_out) begin
      min_value_o       <= res_min_q;
      table_was_empty_o <= res_empty_q;
      dropped_valid_o   <= res_dv_q;
      dropped_value_o   <= res_dval_q;
    end
  end

endmodule

// ----- src/young_tableau_priority_queue_top.sv -----
// top level of the young tableau priority queue: size registers behind the
// apb port, controller and datapath; depends on yt_pkg, yt_ctrl, yt_datapath
//
//   channel  direction  handshake                 payload
//   apb      in/out     psel penable pready       paddr pwrite pwdata prdata
//   request  in         in_valid_i in_stall_o     req_type_i key_value_i
//   result   out        out_valid_o out_stall_i   min_value_o table_was_empty_o
//                                                 dropped_valid_o dropped_value_o
//
// one request at a time: after acceptance the next one waits until the starting
// cell is fetched and all k sift moves are done (k at most rows + cols - 2);
// each move is a memory read step and then a compare-and-write step on the cell store
// after reset a clearing pass writes the empty marker into all
// MaxRows*MaxCols cells, one a cycle, with in_stall_o high throughout
// a finished result sits in the output register; a stalled output only
// holds the block once the next result is ready to be loaded
module young_tableau_priority_queue_top #(
  parameter int MaxRows = yt_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = yt_pkg::MAX_COLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic signed [yt_pkg::DATA_W-1:0] key_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [yt_pkg::DATA_W-1:0] min_value_o,
  output logic                             table_was_empty_o,
  output logic                             dropped_valid_o,
  output logic signed [yt_pkg::DATA_W-1:0] dropped_value_o
);

  logic [yt_pkg::CFG_W-1:0] rows_q, cols_q;
  logic                     cfg_wr;
  yt_pkg::yt_cmd_t          cmd;
  yt_pkg::yt_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= yt_pkg::ROWS_RESET;
      cols_q <= yt_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        yt_pkg::REG_ROWS: rows_q <= pwdata[yt_pkg::CFG_W-1:0];
        yt_pkg::REG_COLS: cols_q <= pwdata[yt_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      yt_pkg::REG_ROWS: prdata = {{(32 - yt_pkg::CFG_W){1'b0}}, rows_q};
      yt_pkg::REG_COLS: prdata = {{(32 - yt_pkg::CFG_W){1'b0}}, cols_q};
      default:          prdata = '0;
    endcase
  end

  yt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  yt_datapath #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .rows_cfg_i        (rows_q),
    .cols_cfg_i        (cols_q),
    .req_type_i        (req_type_i),
    .key_value_i       (key_value_i),
    .min_value_o       (min_value_o),
    .table_was_empty_o (table_was_empty_o),
    .dropped_valid_o   (dropped_valid_o),
    .dropped_value_o   (dropped_value_o)
  );

  // a taken request keeps the input side closed on the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input side open right after a request was taken");

  // a sift move is always followed by a neighbour read
  a_move_then_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval && !stat.stop |=> cmd.read && !cmd.grab)
    else $error("sift move not followed by a neighbour read");

  // an insert never reports an empty table, and an insert result carries no minimum
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_valid_o |->
      !table_was_empty_o && (min_value_o == yt_pkg::KEY_EMPTY))
    else $error("drop flag together with an extract result");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_wr, cmd.start, cmd.fetch, cmd.eval}))
    else $error("conflicting datapath commands");

endmodule

// ----- verif/young_tableau_priority_queue_top_tb.sv -----
// self-checking testbench for young_tableau_priority_queue_top: directed table, then random
// phases over several tableau sizes and idle patterns, results checked against a local model
// depends on yt_pkg and young_tableau_priority_queue_top
module young_tableau_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yt_pkg::*;

  localparam int ROWS = MAX_ROWS_DEF;
  localparam int COLS = MAX_COLS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES = 40;
  localparam logic signed [DATA_W-1:0] KEY_LOWEST = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     table_was_empty;
    logic                     dropped_valid;
    logic signed [DATA_W-1:0] dropped_value;
  } tableau_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    row_kind_e                kind;
    logic                     op;
    logic                     idx;
    logic signed [DATA_W-1:0] arg;
    logic                     typed;
    tableau_result_t          want;
  } directed_row_t;

  localparam tableau_result_t QUIET       = '{KEY_EMPTY, 1'b0, 1'b0, KEY_EMPTY};
  localparam tableau_result_t EMPTY_TAKE  = '{KEY_EMPTY, 1'b1, 1'b0, KEY_EMPTY};
  localparam tableau_result_t LOWEST_TAKE = '{KEY_LOWEST, 1'b0, 1'b0, KEY_EMPTY};

  localparam int PLAN_LEN = 33;
  localparam directed_row_t PLAN [PLAN_LEN] = '{
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b1, EMPTY_TAKE},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, KEY_EMPTY,      1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, KEY_LOWEST,     1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sh7FFF_FFFE, 1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd0,         1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, -32'sd1,        1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd7,         1'b1, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd7,         1'b1, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b1, LOWEST_TAKE},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, -32'sd1,        1'b0, QUIET},
    // shrink to one row of two while filled
    '{ROW_CONFIG,  OP_INSERT,  REG_ROWS, 32'sd1,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_COLS, 32'sd2,         1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd3,         1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd2,         1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, KEY_EMPTY,      1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET},
    // out of range sizes clamp
    '{ROW_CONFIG,  OP_INSERT,  REG_ROWS, 32'sd0,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_COLS, 32'sd15,        1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd100,       1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_ROWS, 32'sd15,        1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_COLS, 32'sd0,         1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, -32'sd5,        1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET},
    // single cell tableau
    '{ROW_CONFIG,  OP_INSERT,  REG_ROWS, 32'sd1,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_COLS, 32'sd1,         1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, 32'sd42,        1'b0, QUIET},
    '{ROW_REQUEST, OP_INSERT,  REG_ROWS, -32'sd42,       1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_ROWS, 32'sd8,         1'b0, QUIET},
    '{ROW_CONFIG,  OP_INSERT,  REG_COLS, 32'sd8,         1'b0, QUIET},
    '{ROW_REQUEST, OP_EXTRACT, REG_ROWS, 32'sd0,         1'b0, QUIET}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i = OP_INSERT;
  logic signed [DATA_W-1:0] key_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] min_value_o;
  logic                     table_was_empty_o;
  logic                     dropped_valid_o;
  logic signed [DATA_W-1:0] dropped_value_o;

  // local copy of the tableau and size registers
  logic signed [DATA_W-1:0] cell_grid [ROWS][COLS];
  logic [CFG_W-1:0]         rows_reg = ROWS_RESET;
  logic [CFG_W-1:0]         cols_reg = COLS_RESET;

  tableau_result_t owed_results [$];
  idle_mode_e      idle_mode = IDLE_NONE;
  int              mismatches = 0;
  int              hold_asks = 0;

  always #6 clk_i = ~clk_i;

  young_tableau_priority_queue_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .key_value_i       (key_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .min_value_o       (min_value_o),
    .table_was_empty_o (table_was_empty_o),
    .dropped_valid_o   (dropped_valid_o),
    .dropped_value_o   (dropped_value_o)
  );

  function automatic int used_extent(logic [CFG_W-1:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // insert sifts the key up or left from the last used cell, extract sifts the hole
  // down or right from the corner
  function automatic tableau_result_t apply_request(logic op, logic signed [DATA_W-1:0] key);
    tableau_result_t res;
    int nr;
    int nc;
    int r;
    int c;
    bit done;
    bit go_up;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] down;
    logic signed [DATA_W-1:0] right;
    nr = used_extent(rows_reg, ROWS);
    nc = used_extent(cols_reg, COLS);
    res = QUIET;
    done = 1'b0;
    if (op == OP_INSERT) begin
      r = nr - 1;
      c = nc - 1;
      if (cell_grid[r][c] != KEY_EMPTY) begin
        res.dropped_valid = 1'b1;
        res.dropped_value = cell_grid[r][c];
      end
      while (!done) begin
        up = (r > 0) ? cell_grid[r-1][c] : KEY_EMPTY;
        left = (c > 0) ? cell_grid[r][c-1] : KEY_EMPTY;
        if (r > 0 && c > 0) go_up = (up >= left);
        else go_up = (r > 0);
        if (r == 0 && c == 0) begin
          done = 1'b1;
        end else if (go_up) begin
          if (up <= key) done = 1'b1;
          else begin
            cell_grid[r][c] = up;
            r--;
          end
        end else begin
          if (left <= key) done = 1'b1;
          else begin
            cell_grid[r][c] = left;
            c--;
          end
        end
      end
      cell_grid[r][c] = key;
    end else begin
      res.min_value = cell_grid[0][0];
      res.table_was_empty = (cell_grid[0][0] == KEY_EMPTY);
      r = 0;
      c = 0;
      while (!done) begin
        down = (r + 1 < nr) ? cell_grid[r+1][c] : KEY_EMPTY;
        right = (c + 1 < nc) ? cell_grid[r][c+1] : KEY_EMPTY;
        if (down == KEY_EMPTY && right == KEY_EMPTY) begin
          done = 1'b1;
        end else if (down <= right) begin
          cell_grid[r][c] = down;
          r++;
        end else begin
          cell_grid[r][c] = right;
          c++;
        end
      end
      cell_grid[r][c] = KEY_EMPTY;
    end
    return res;
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 87;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 87;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return KEY_EMPTY;
      1:       return KEY_LOWEST;
      2:       return KEY_EMPTY - 1;
      3, 4:    return DATA_W'($urandom_range(20)) - 10;  // small range for ties
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic signed [DATA_W-1:0] got,
                               logic signed [DATA_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic take_result();
    tableau_result_t want;
    if (owed_results.size() == 0) begin
      flag_mismatch("result with no request pending, min_value", min_value_o, KEY_EMPTY);
      return;
    end
    want = owed_results.pop_front();
    if (min_value_o !== want.min_value)
      flag_mismatch("min_value", min_value_o, want.min_value);
    if (table_was_empty_o !== want.table_was_empty)
      flag_mismatch("table_was_empty", table_was_empty_o, want.table_was_empty);
    if (dropped_valid_o !== want.dropped_valid)
      flag_mismatch("dropped_valid", dropped_valid_o, want.dropped_valid);
    if (dropped_value_o !== want.dropped_value)
      flag_mismatch("dropped_value", dropped_value_o, want.dropped_value);
  endtask

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_req(logic op, logic signed [DATA_W-1:0] key, logic typed,
                          tableau_result_t want);
    tableau_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= op;
    key_value_i <= key;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = apply_request(op, key);
    owed_results.insert(owed_results.size(), typed ? want : predicted);
  endtask

  task automatic wait_all_returned();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic idx, logic [CFG_W-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {28'($urandom()), v};  // upper bits must be ignored
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (idx == REG_ROWS) rows_reg = v;
    else cols_reg = v;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] nrows, logic [CFG_W-1:0] ncols,
                           idle_mode_e mode, int count, bit squeeze);
    int burst_left;
    int insert_pct;
    logic op;
    burst_left = 0;
    insert_pct = 50;
    wait_all_returned();
    write_size(REG_ROWS, nrows);
    write_size(REG_COLS, ncols);
    idle_mode = mode;
    // long receiver hold while requests keep coming, so the block backs up
    if (squeeze) hold_asks++;
    for (int n = 0; n < count; n++) begin
      // bursts that mostly fill, mostly drain, or churn
      if (burst_left == 0) begin
        burst_left = $urandom_range(80, 20);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      burst_left--;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
      send_req(op, (op == OP_INSERT) ? pick_key() : DATA_W'($urandom()), 1'b0, QUIET);
    end
  endtask

  initial begin : result_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct());
      end
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) take_result();
    end
  end

  initial begin : request_side
    foreach (cell_grid[r, c]) cell_grid[r][c] = KEY_EMPTY;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CONFIG) begin
        wait_all_returned();
        write_size(PLAN[i].idx, PLAN[i].arg[CFG_W-1:0]);
      end else begin
        send_req(PLAN[i].op, PLAN[i].arg, PLAN[i].typed, PLAN[i].want);
      end
    end

    run_phase(4'd8,  4'd8,  IDLE_NONE, 250, 1'b0);
    run_phase(4'd8,  4'd8,  IDLE_SEND, 200, 1'b0);
    run_phase(4'd2,  4'd3,  IDLE_RECV, 200, 1'b0);
    run_phase(4'd8,  4'd8,  IDLE_BOTH, 250, 1'b0);
    run_phase(4'd1,  4'd8,  IDLE_BOTH, 150, 1'b0);
    run_phase(4'd8,  4'd1,  IDLE_SEND, 150, 1'b0);
    run_phase(4'd0,  4'd15, IDLE_RECV, 150, 1'b0);
    run_phase(4'd15, 4'd0,  IDLE_NONE, 100, 1'b0);
    run_phase(4'($urandom()), 4'($urandom()), IDLE_BOTH, 200, 1'b0);
    run_phase(4'd8,  4'd8,  IDLE_NONE, 60,  1'b1);

    wait_all_returned();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
